// ===== hw/rtl/hbq_pkg.sv =====
// Shared constants and types of the high-pass biquad filter.
`default_nettype none

package hbq_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int CFG_ADDR_WIDTH = 2;

    localparam int DIFF_WIDTH = SAMPLE_WIDTH + 2;
    localparam int PROD_WIDTH = COEF_WIDTH + DIFF_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 2;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_B0 = CFG_ADDR_WIDTH'(0);
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_A1 = CFG_ADDR_WIDTH'(1);
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_A2 = CFG_ADDR_WIDTH'(2);

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } coef_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x1;
        logic signed [SAMPLE_WIDTH-1:0] x2;
        logic signed [SAMPLE_WIDTH-1:0] y1;
        logic signed [SAMPLE_WIDTH-1:0] y2;
        logic                           warmup;
    } hist_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hbq_coef_regs.sv =====
// Coefficient registers written through the configuration port.
`default_nettype none

module hbq_coef_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [hbq_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  wire logic [hbq_pkg::COEF_WIDTH-1:0]      cfg_wdata,
    output hbq_pkg::coef_t                           coef
);

    hbq_pkg::coef_t coef_reg;
    hbq_pkg::coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                hbq_pkg::REG_B0: coef_next.b0 = cfg_wdata;
                hbq_pkg::REG_A1: coef_next.a1 = cfg_wdata;
                hbq_pkg::REG_A2: coef_next.a2 = cfg_wdata;
                default:         coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hbq_mac.sv =====
// Multiply-accumulate, rounding and saturation for one filter sample, with a zero result for a start or warm-up word.
`default_nettype none

module hbq_mac (
    input  wire hbq_pkg::coef_t                           coef,
    input  wire hbq_pkg::hist_t                           hist,
    input  wire logic signed [hbq_pkg::SAMPLE_WIDTH-1:0]  sample,
    input  wire logic                                     start,
    output logic signed [hbq_pkg::SAMPLE_WIDTH-1:0]       result
);

    localparam int SW = hbq_pkg::SAMPLE_WIDTH;
    localparam int DW = hbq_pkg::DIFF_WIDTH;
    localparam int PW = hbq_pkg::PROD_WIDTH;
    localparam int AW = hbq_pkg::ACC_WIDTH;
    localparam int CW = hbq_pkg::COEF_WIDTH;
    localparam int FB = hbq_pkg::COEF_FRAC_BITS;

    localparam logic signed [AW-1:0] ROUND = AW'(1) <<< (FB - 1);
    localparam logic signed [AW-1:0] SMAX  = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN  = ~SMAX;

    logic signed [DW-1:0]    diff;
    logic signed [PW-1:0]    prod_b;
    logic signed [CW+SW-1:0] prod_a1;
    logic signed [CW+SW-1:0] prod_a2;
    logic signed [AW-1:0]    acc;
    logic signed [AW-1:0]    shifted;

    // The numerator taps share b0: b0*x - 2*b0*x1 + b0*x2 = b0*(x + x2 - 2*x1).
    assign diff    = DW'(sample) + DW'(hist.x2) - (DW'(hist.x1) <<< 1);
    assign prod_b  = PW'(coef.b0) * PW'(diff);
    assign prod_a1 = (CW+SW)'(coef.a1) * (CW+SW)'(hist.y1);
    assign prod_a2 = (CW+SW)'(coef.a2) * (CW+SW)'(hist.y2);
    assign acc     = AW'(prod_b) - AW'(prod_a1) - AW'(prod_a2) + ROUND;
    assign shifted = acc >>> FB;

    always_comb
    begin
        if (start || hist.warmup)
        begin
            result = '0;
        end
        else if (shifted > SMAX)
        begin
            result = SMAX[SW-1:0];
        end
        else if (shifted < SMIN)
        begin
            result = SMIN[SW-1:0];
        end
        else
        begin
            result = shifted[SW-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/highpass_biquad_filter_top.sv =====
// Top level of the direct form I high-pass biquad filter with stream ports.
//
// Input words arrive on the s_axis channel: tdata carries the signed sample
// and tuser the start-of-buffer flag. Filtered words leave on the m_axis
// channel. The coefficients b0, a1 and a2 are written through the plain
// configuration port (index 0, 1 and 2), by the user only while no word
// is in flight; the block itself does not enforce this. A word is captured
// in an input register; its result is then computed in a single pass and
// stored in the output register. One word is taken in every cycle while the
// receiver does not stall; the feedback path through the combinational
// multiply-accumulate sets this rate.
// A start flag clears the output history and makes the first two results of
// the buffer zero while the input history still takes those samples.
// Reset clears the coefficients, the history and both valid flags.
// When the receiver stalls, the result waits in the output register and one
// further word is held in the input register before tready falls.
`default_nettype none

module highpass_biquad_filter_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [hbq_pkg::SAMPLE_WIDTH-1:0]    s_axis_tdata,  // sample_in
    input  wire logic                                s_axis_tuser,  // start_of_buffer
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [hbq_pkg::SAMPLE_WIDTH-1:0]         m_axis_tdata,  // sample_out
    input  wire logic                                cfg_wr_en,
    input  wire logic [hbq_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  wire logic [hbq_pkg::COEF_WIDTH-1:0]      cfg_wdata
);

    localparam int SW = hbq_pkg::SAMPLE_WIDTH;

    hbq_pkg::coef_t coef;
    hbq_pkg::hist_t hist_reg;
    hbq_pkg::hist_t hist_next;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic signed [SW-1:0] in_sample_reg;
    logic                 in_start_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [SW-1:0] out_sample_reg;
    logic signed [SW-1:0] result;
    logic                 s_fire;
    logic                 m_fire;
    logic                 advance;

    hbq_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    hbq_mac u_mac (
        .coef   (coef),
        .hist   (hist_reg),
        .sample (in_sample_reg),
        .start  (in_start_reg),
        .result (result)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = out_valid_reg && m_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_fire)
        begin
            out_valid_next = 1'b0;
        end

        hist_next = hist_reg;
        if (advance)
        begin
            hist_next.x2     = hist_reg.x1;
            hist_next.x1     = in_sample_reg;
            hist_next.y2     = in_start_reg ? '0 : hist_reg.y1;
            hist_next.y1     = result;
            hist_next.warmup = in_start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_sample_reg <= s_axis_tdata;
            in_start_reg  <= s_axis_tuser;
        end
        if (advance)
        begin
            out_sample_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;

`ifndef SYNTHESIS
    // A word that opens a buffer always leaves as zero and arms the warm-up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_start_reg) |=> (m_axis_tdata == '0 && hist_reg.warmup))
        else $error("start word did not give a zero result");

    // The newest output history entry is the word just placed on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (hist_reg.y1 == out_sample_reg))
        else $error("output history out of step with result");

    // A stalled result is neither dropped nor replaced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_sample_reg)))
        else $error("stalled result lost");

    // The input register is never overwritten while it holds a pending word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !s_axis_tready)
        else $error("pending input word overwritten");
`endif

endmodule

`default_nettype wire

// ===== test/hbq_response_checker.sv =====
// Checker that predicts every filtered word of the high-pass biquad and compares it with the output.
module hbq_response_checker
    import hbq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    input  wire logic                      s_axis_tready,
    input  wire logic [SAMPLE_WIDTH-1:0]   s_axis_tdata,  // sample_in
    input  wire logic                      s_axis_tuser,  // start_of_buffer
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    input  wire logic [SAMPLE_WIDTH-1:0]   m_axis_tdata,  // sample_out
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [COEF_WIDTH-1:0]     cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_MAX    = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAT_MIN    = -SAT_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);
    localparam longint B1_SCALE   = 2;

    coef_t                          coefs;
    hist_t                          hist;
    logic signed [SAMPLE_WIDTH-1:0] expected_outputs[$];
    logic signed [SAMPLE_WIDTH-1:0] predicted;
    logic signed [SAMPLE_WIDTH-1:0] observed;

    function automatic logic signed [SAMPLE_WIDTH-1:0] filtered_sample(
        input coef_t                          c,
        input hist_t                          h,
        input logic signed [SAMPLE_WIDTH-1:0] x
    );
        longint acc;
        longint y;
        acc = longint'(c.b0) * longint'(x)
            - B1_SCALE * longint'(c.b0) * longint'(h.x1)
            + longint'(c.b0) * longint'(h.x2)
            - longint'(c.a1) * longint'(h.y1)
            - longint'(c.a2) * longint'(h.y2);
        y = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
        if (y > SAT_MAX)
        begin
            y = SAT_MAX;
        end
        else if (y < SAT_MIN)
        begin
            y = SAT_MIN;
        end
        return y[SAMPLE_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs = '0;
            hist  = '0;
            expected_outputs.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed = m_axis_tdata;
                if (expected_outputs.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: output word with none expected, expected nothing, actual %0d",
                             $time, observed);
                end
                else
                begin
                    predicted = expected_outputs.pop_front();
                    checked++;
                    if (observed !== predicted)
                    begin
                        fail_count++;
                        $display("%0t: sample_out wrong, expected %0d, actual %0d",
                                 $time, predicted, observed);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser || hist.warmup)
                begin
                    predicted = '0;
                end
                else
                begin
                    predicted = filtered_sample(coefs, hist, s_axis_tdata);
                end
                hist.x2     = hist.x1;
                hist.x1     = s_axis_tdata;
                hist.y2     = s_axis_tuser ? '0 : hist.y1;
                hist.y1     = predicted;
                hist.warmup = s_axis_tuser;
                expected_outputs.push_back(predicted);
            end

            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_B0:  coefs.b0 = cfg_wdata;
                    REG_A1:  coefs.a1 = cfg_wdata;
                    REG_A2:  coefs.a2 = cfg_wdata;
                    default: ;
                endcase
            end

            pending = expected_outputs.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the high-pass biquad testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hbq_pkg::*;

    typedef enum int {WAVE_FULL, WAVE_SMALL, WAVE_EXTREME, WAVE_STEP} wave_e;

    localparam int PHASES      = 11;
    localparam int PHASE_WORDS = 100;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [SAMPLE_WIDTH-1:0]   s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [SAMPLE_WIDTH-1:0]   m_axis_tdata;
    logic                      cfg_wr_en;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [COEF_WIDTH-1:0]     cfg_wdata;

    int fail_count;
    int pending;
    int checked;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_tokens;
    int hold_seen;
    int hold_left;
    int words_sent;
    int starts_sent;
    int settings_used;

    highpass_biquad_filter_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    hbq_response_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d filtered words still outstanding.", pending);
        $display("highpass_biquad_filter_top: mismatch");
        $finish;
    end

    // A hold-off request is counted here so that the sender keeps offering words meanwhile.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_seen     = 0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_seen != hold_tokens)
            begin
                hold_seen++;
                hold_left = 60;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic sob);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= sob;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        if (sob)
        begin
            starts_sent++;
        end
        @(negedge clk);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic write_coefs(
        input logic signed [COEF_WIDTH-1:0] b0,
        input logic signed [COEF_WIDTH-1:0] a1,
        input logic signed [COEF_WIDTH-1:0] a2
    );
        drain_outputs();
        repeat (4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_B0;
        cfg_wdata <= b0;
        @(negedge clk);
        cfg_addr  <= REG_A1;
        cfg_wdata <= a1;
        @(negedge clk);
        cfg_addr  <= REG_A2;
        cfg_wdata <= a2;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic signed [COEF_WIDTH-1:0]   c_b0;
        logic signed [COEF_WIDTH-1:0]   c_a1;
        logic signed [COEF_WIDTH-1:0]   c_a2;
        logic signed [SAMPLE_WIDTH-1:0] smp;
        logic signed [SAMPLE_WIDTH-1:0] level;
        logic                           sob;
        logic                           sob_first;
        logic                           paused;
        wave_e                          kind;
        int                             buf_len;
        int                             sent_here;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_B0;
        cfg_wdata     = '0;
        tx_idle_pct   = 12;
        rx_idle_pct   = 12;
        hold_tokens   = 0;
        words_sent    = 0;
        starts_sent   = 0;
        settings_used = 0;
        paused        = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset coefficients, no start flag since reset.
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh0001, 1'b0);

        write_coefs(16'sd13116, -16'sd25575, 16'sd10508);
        send_word(16'sh7fff, 1'b1);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh0000, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sh0001, 1'b0);
        send_word(16'sh0000, 1'b1);
        send_word(16'sd100, 1'b1);
        send_word(16'sd200, 1'b0);
        send_word(16'sd300, 1'b0);
        send_word(16'sh8000, 1'b1);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh8000, 1'b0);

        // Extreme gains drive the sum well past the sample range.
        write_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
        send_word(16'sh0000, 1'b1);
        send_word(16'sh0000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin c_b0 = 16'sd15672; c_a1 = -16'sd31313; c_a2 = 16'sd14991; end
                1:       begin c_b0 = 16'sd10469; c_a1 = -16'sd18727; c_a2 = 16'sd6763;  end
                2:       begin c_b0 = 16'sd4799;  c_a1 = 16'sd0;      c_a2 = 16'sd2811;  end
                3:       begin c_b0 = 16'sh7fff;  c_a1 = 16'sh7fff;   c_a2 = 16'sh7fff;  end
                4:       begin c_b0 = 16'sh8000;  c_a1 = 16'sh8000;   c_a2 = 16'sh8000;  end
                5:       begin c_b0 = 16'sh7fff;  c_a1 = 16'sd0;      c_a2 = 16'sd0;     end
                8:       begin c_b0 = 16'sh8000;  c_a1 = 16'sh7fff;   c_a2 = 16'sh8000;  end
                9:       begin c_b0 = 16'sd13116; c_a1 = -16'sd25575; c_a2 = 16'sd10508; end
                default:
                begin
                    c_b0 = COEF_WIDTH'($urandom);
                    c_a1 = COEF_WIDTH'($urandom);
                    c_a2 = COEF_WIDTH'($urandom);
                end
            endcase
            write_coefs(c_b0, c_a1, c_a2);

            tx_idle_pct = (p == 2) ? 0 : 12;
            rx_idle_pct = (p == 2) ? 0 : 12;
            if (p == 1)
            begin
                hold_tokens++;
            end

            sent_here = 0;
            while (sent_here < PHASE_WORDS)
            begin
                if (p == 5 && sent_here >= PHASE_WORDS / 2 && !paused)
                begin
                    drain_outputs();
                    paused = 1'b1;
                end
                buf_len   = ($urandom_range(9) == 0) ? $urandom_range(1, 2)
                                                     : $urandom_range(3, 40);
                sob_first = ($urandom_range(9) != 0);
                kind      = wave_e'($urandom_range(3));
                level     = SAMPLE_WIDTH'($urandom);
                for (int i = 0; i < buf_len; i++)
                begin
                    case (kind)
                        WAVE_FULL:    smp = SAMPLE_WIDTH'($urandom);
                        WAVE_SMALL:   smp = SAMPLE_WIDTH'($urandom_range(1023) - 512);
                        WAVE_EXTREME: smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                        default:      smp = SAMPLE_WIDTH'(level + $urandom_range(3));
                    endcase
                    sob = (i == 0) ? sob_first : ($urandom_range(49) == 0);
                    send_word(smp, sob);
                end
                sent_here += buf_len;
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);

        $display("Run covered %0d input words with %0d buffer starts over %0d coefficient settings.",
                 words_sent, starts_sent, settings_used);
        $display("%0d filtered words were compared under random stalls and a long output hold-off.",
                 checked);
        if (fail_count == 0 && pending == 0)
        begin
            $display("highpass_biquad_filter_top: match");
        end
        else
        begin
            $display("highpass_biquad_filter_top: mismatch");
        end
        $finish;
    end

endmodule
